[hw/rtl/tts_pkg.sv]
// tts_pkg: shared types and constants of the text terminal scrollback unit
// payload structs for the input and result words, operation and character codes
// no dependencies
package tts_pkg;

  typedef logic [15:0] cell_t;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] character;
    logic [7:0] amount;
    logic [4:0] view_row;
    logic [6:0] view_column;
  } item_t;

  typedef struct packed {
    logic [15:0] cell_value;
    logic [10:0] cursor_position;
    logic        cursor_visible;
    logic [7:0]  scrolled_back;
  } result_t;

  // operation codes
  localparam logic [2:0] OP_PUT_CHAR      = 3'd0;
  localparam logic [2:0] OP_ERASE         = 3'd1;
  localparam logic [2:0] OP_SCROLL_UP     = 3'd2;
  localparam logic [2:0] OP_SCROLL_DOWN   = 3'd3;
  localparam logic [2:0] OP_SCROLL_BOTTOM = 3'd4;
  localparam logic [2:0] OP_CLEAR         = 3'd5;
  localparam logic [2:0] OP_READ_CELL     = 3'd6;

  // character codes
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_RETURN    = 8'h0D;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_PRINT_LO  = 8'h20;
  localparam logic [7:0] CH_PRINT_HI  = 8'h7F;

  localparam logic [7:0] ATTR_RESET = 8'h07;

endpackage

[hw/rtl/tts_cell_ram.sv]
// tts_cell_ram: cell store of the scrollback ring, one write and one read port
// read data registered, valid in the cycle after re_i; uses tts_pkg
module tts_cell_ram
  import tts_pkg::*;
#(
  parameter int Depth = 20480,
  parameter int AddrW = 15
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  cell_t            wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output cell_t            rdata_o
);

  cell_t mem [Depth];
  cell_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/text_terminal_scrollback_unit.sv]
// text_terminal_scrollback_unit: text terminal engine over a ring of history lines
// sequencer with line base tracking, blank fill and read path; uses tts_pkg, tts_cell_ram
//
// channel  | direction | handshake                 | word
// ---------+-----------+---------------------------+-------------------------------
// in       | input     | in_valid_i / in_ready_o   | in_data_i (item_t)
// out      | output    | out_valid_o / out_ready_i | out_data_o (result_t)
// cfg      | input     | cfg_we_i, no wait         | cfg_wdata_i (attribute byte)
//
// each word passes accept, execute and result; a character on a started line adds a
// store step, a newline or clear a blank fill of the line, a character that wraps or
// the first one with no line both; read_cell adds slot, address and data steps, past
// the written lines only the slot step, and outside the window none.
// the blank fill of a new line through the single memory write port sets the long cases.
// reset clears control state only; the cell store needs no clearing pass since a
// line is always blanked when it is started, before any of its cells is read.
// a result waiting in the output register does not stop the next word being
// accepted; only the final step of that word waits for the register to free up.
module text_terminal_scrollback_unit
  import tts_pkg::*;
#(
  parameter int HISTORY_LINES = 256,
  parameter int COLUMNS       = 80,
  parameter int ROWS          = 25
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  item_t      in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output result_t    out_data_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);

  localparam int Depth  = HISTORY_LINES * COLUMNS;
  localparam int AddrW  = $clog2(Depth);
  localparam int SlotW  = $clog2(HISTORY_LINES);
  localparam int LcW    = $clog2(HISTORY_LINES + 1);
  localparam int ColW   = $clog2(COLUMNS);
  localparam int CmpW   = LcW + 8;              // room for sums, ROWS and COLUMNS
  localparam int PosW   = CmpW + 8;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_FILL  = 3'd2;
  localparam logic [2:0] S_PUT   = 3'd3;
  localparam logic [2:0] S_RSLOT = 3'd4;
  localparam logic [2:0] S_RADDR = 3'd5;
  localparam logic [2:0] S_RDATA = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]       state_q, state_d;
  item_t            req_q, req_d;
  logic [7:0]       attr_q;
  logic [SlotW-1:0] newest_q, newest_d;     // ring slot of the newest line
  logic [AddrW-1:0] base_q, base_d;         // newest_q * COLUMNS, kept incrementally
  logic [LcW-1:0]   lc_q, lc_d;             // retained lines
  logic [ColW-1:0]  col_q, col_d;           // write column
  logic [LcW-1:0]   vb_q, vb_d;             // view lines above bottom
  logic [ColW-1:0]  fill_q, fill_d;         // blank fill column
  logic             pend_q, pend_d;         // character still to store after fill
  logic [CmpW-1:0]  idx_q, idx_d;           // history index of the read row
  logic [SlotW-1:0] slot_q, slot_d;         // ring slot of the read row
  cell_t            cell_q, cell_d;
  result_t          out_q, out_d;
  logic             out_valid_q, out_valid_d;

  // memory port
  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  cell_t            ram_wdata, ram_rdata;

  tts_cell_ram #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // shared terms
  cell_t            blank;
  logic [SlotW-1:0] nl_newest;
  logic [AddrW-1:0] nl_base;
  logic [LcW-1:0]   nl_lc;
  logic [CmpW-1:0]  max_back;
  logic [CmpW-1:0]  scroll_sum;
  logic [CmpW-1:0]  read_top;
  logic [LcW-1:0]   age;
  logic [SlotW:0]   slot_diff;
  logic [CmpW-1:0]  lc_min;
  logic [CmpW-1:0]  crow;
  logic [PosW-1:0]  pos_wide;
  logic             cur_vis;
  logic             printable;

  assign blank = {attr_q, CH_SPACE};

  // next ring slot when a line is started
  always_comb begin
    if (lc_q == '0) begin
      nl_newest = '0;
      nl_base   = '0;
    end else if (newest_q == SlotW'(HISTORY_LINES - 1)) begin
      nl_newest = '0;
      nl_base   = '0;
    end else begin
      nl_newest = newest_q + SlotW'(1);
      nl_base   = base_q + AddrW'(COLUMNS);
    end
    nl_lc = (lc_q == LcW'(HISTORY_LINES)) ? lc_q : lc_q + LcW'(1);
  end

  // scroll limits and read row mapping
  assign max_back   = (CmpW'(lc_q) > CmpW'(ROWS)) ? CmpW'(lc_q) - CmpW'(ROWS) : '0;
  assign scroll_sum = CmpW'(vb_q) + CmpW'(req_q.amount);
  assign read_top   = max_back - CmpW'(vb_q);
  assign age        = LcW'(CmpW'(lc_q) - CmpW'(1) - idx_q);
  assign slot_diff  = {1'b0, newest_q} - (SlotW + 1)'(age);

  // cursor: visible row of the newest line
  assign lc_min   = (CmpW'(lc_q) < CmpW'(ROWS)) ? CmpW'(lc_q) : CmpW'(ROWS);
  assign crow     = lc_min - CmpW'(1) + CmpW'(vb_q);
  assign cur_vis  = (lc_q != '0) && (crow < CmpW'(ROWS));
  assign pos_wide = PosW'(crow) * PosW'(COLUMNS) + PosW'(col_q);

  assign printable = (req_q.character >= CH_PRINT_LO) && (req_q.character <= CH_PRINT_HI);

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    newest_d    = newest_q;
    base_d      = base_q;
    lc_d        = lc_q;
    col_d       = col_q;
    vb_d        = vb_q;
    fill_d      = fill_q;
    pend_d      = pend_q;
    idx_d       = idx_q;
    slot_d      = slot_q;
    cell_d      = cell_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    ram_we      = 1'b0;
    ram_waddr   = base_q + AddrW'(col_q);
    ram_wdata   = blank;
    ram_re      = 1'b0;
    ram_raddr   = AddrW'(slot_q) * AddrW'(COLUMNS) + AddrW'(req_q.view_column);

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_data_i;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        cell_d  = '0;
        state_d = S_DONE;
        unique case (req_q.operation)
          OP_PUT_CHAR: begin
            priority if (req_q.character == CH_NEWLINE) begin
              newest_d = nl_newest;
              base_d   = nl_base;
              lc_d     = nl_lc;
              col_d    = '0;
              vb_d     = '0;
              fill_d   = '0;
              pend_d   = 1'b0;
              state_d  = S_FILL;
            end else if (req_q.character == CH_BACKSPACE) begin
              if (lc_q != '0 && col_q != '0) begin
                col_d     = col_q - ColW'(1);
                ram_we    = 1'b1;
                ram_waddr = base_q + AddrW'(col_q - ColW'(1));
              end
            end else if (req_q.character == CH_RETURN) begin
              col_d = '0;
            end else if (!printable) begin
              // other control codes and high bytes are dropped
            end else if (lc_q == '0) begin
              // no line yet: blank one first, then store the character
              newest_d = nl_newest;
              base_d   = nl_base;
              lc_d     = nl_lc;
              col_d    = '0;
              vb_d     = '0;
              fill_d   = '0;
              pend_d   = 1'b1;
              state_d  = S_FILL;
            end else begin
              state_d = S_PUT;
            end
          end
          OP_ERASE: begin
            if (lc_q != '0 && col_q != '0) begin
              col_d     = col_q - ColW'(1);
              ram_we    = 1'b1;
              ram_waddr = base_q + AddrW'(col_q - ColW'(1));
            end
          end
          OP_SCROLL_UP: begin
            vb_d = (scroll_sum > max_back) ? LcW'(max_back) : LcW'(scroll_sum);
          end
          OP_SCROLL_DOWN: begin
            vb_d = (CmpW'(req_q.amount) >= CmpW'(vb_q)) ? '0
                 : LcW'(CmpW'(vb_q) - CmpW'(req_q.amount));
          end
          OP_SCROLL_BOTTOM: begin
            vb_d = '0;
          end
          OP_CLEAR: begin
            newest_d = '0;
            base_d   = '0;
            lc_d     = LcW'(1);
            col_d    = '0;
            vb_d     = '0;
            fill_d   = '0;
            pend_d   = 1'b0;
            state_d  = S_FILL;
          end
          OP_READ_CELL: begin
            if (CmpW'(req_q.view_row) < CmpW'(ROWS) &&
                CmpW'(req_q.view_column) < CmpW'(COLUMNS)) begin
              idx_d   = read_top + CmpW'(req_q.view_row);
              state_d = S_RSLOT;
            end
          end
          default: begin
          end
        endcase
      end

      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = base_q + AddrW'(fill_q);
        if (fill_q == ColW'(COLUMNS - 1)) begin
          fill_d  = '0;
          pend_d  = 1'b0;
          state_d = pend_q ? S_PUT : S_DONE;
        end else begin
          fill_d = fill_q + ColW'(1);
        end
      end

      S_PUT: begin
        ram_we    = 1'b1;
        ram_wdata = {attr_q, req_q.character};
        if (col_q == ColW'(COLUMNS - 1)) begin
          // line full: wrap onto a fresh blank line
          newest_d = nl_newest;
          base_d   = nl_base;
          lc_d     = nl_lc;
          col_d    = '0;
          vb_d     = '0;
          fill_d   = '0;
          pend_d   = 1'b0;
          state_d  = S_FILL;
        end else begin
          col_d   = col_q + ColW'(1);
          state_d = S_DONE;
        end
      end

      S_RSLOT: begin
        if (idx_q >= CmpW'(lc_q)) begin
          // row past the written lines
          cell_d  = blank;
          state_d = S_DONE;
        end else begin
          slot_d  = slot_diff[SlotW] ? SlotW'(slot_diff + (SlotW + 1)'(HISTORY_LINES))
                                     : slot_diff[SlotW-1:0];
          state_d = S_RADDR;
        end
      end

      S_RADDR: begin
        ram_re  = 1'b1;
        state_d = S_RDATA;
      end

      S_RDATA: begin
        cell_d  = ram_rdata;
        state_d = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.cell_value      = cell_q;
          out_d.cursor_position = cur_vis ? pos_wide[10:0] : 11'd0;
          out_d.cursor_visible  = cur_vis;
          out_d.scrolled_back   = 8'(vb_q);
          out_valid_d           = 1'b1;
          state_d               = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      attr_q      <= ATTR_RESET;
      newest_q    <= '0;
      base_q      <= '0;
      lc_q        <= '0;
      col_q       <= '0;
      vb_q        <= '0;
      fill_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      newest_q    <= newest_d;
      base_q      <= base_d;
      lc_q        <= lc_d;
      col_q       <= col_d;
      vb_q        <= vb_d;
      fill_q      <= fill_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        attr_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    idx_q  <= idx_d;
    slot_q <= slot_d;
    cell_q <= cell_d;
    out_q  <= out_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[dv/tts_scoreboard_pkg.sv]
// tts_scoreboard_pkg: shadow terminal and result checker for the scrollback unit bench
// keeps its own copy of the line ring, cursor and view offset; uses tts_pkg
package tts_scoreboard_pkg;
  import tts_pkg::*;

  localparam int TERM_HISTORY = 256;
  localparam int TERM_COLUMNS = 80;
  localparam int TERM_ROWS    = 25;

  class terminal_scoreboard;
    logic [15:0]  shadow_cells [TERM_HISTORY*TERM_COLUMNS];
    int unsigned  newest_slot;
    int unsigned  line_total;
    int unsigned  cursor_col;
    int unsigned  lines_back;
    logic [7:0]   attr;
    result_t      pending_status [$];
    int unsigned  failures;

    function new();
      foreach (shadow_cells[i]) shadow_cells[i] = '0;
      newest_slot = 0;
      line_total  = 0;
      cursor_col  = 0;
      lines_back  = 0;
      attr        = ATTR_RESET;
      failures    = 0;
    endfunction

    function void set_attr(logic [7:0] value);
      attr = value;
    endfunction

    function int unsigned pending();
      return pending_status.size();
    endfunction

    function logic [15:0] blank();
      return {attr, CH_SPACE};
    endfunction

    // deepest view offset that still shows retained lines only
    function int unsigned deepest_back();
      return (line_total > TERM_ROWS) ? line_total - TERM_ROWS : 0;
    endfunction

    function void start_line();
      if (line_total == 0) newest_slot = 0;
      else newest_slot = (newest_slot + 1) % TERM_HISTORY;
      for (int x = 0; x < TERM_COLUMNS; x++)
        shadow_cells[newest_slot*TERM_COLUMNS + x] = blank();
      if (line_total < TERM_HISTORY) line_total++;
      cursor_col = 0;
      lines_back = 0;
    endfunction

    function void erase_cell();
      if (line_total == 0 || cursor_col == 0) return;
      cursor_col--;
      shadow_cells[newest_slot*TERM_COLUMNS + cursor_col] = blank();
    endfunction

    // apply one accepted word and queue the status it must produce
    function void apply_word(item_t w);
      result_t     r;
      int unsigned span;
      int unsigned idx;
      int unsigned slot;
      int unsigned crow;
      r = '0;
      case (w.operation)
        OP_PUT_CHAR: begin
          if (w.character == CH_NEWLINE) start_line();
          else if (w.character == CH_BACKSPACE) erase_cell();
          else if (w.character == CH_RETURN) cursor_col = 0;
          else if (w.character >= CH_PRINT_LO && w.character <= CH_PRINT_HI) begin
            if (line_total == 0) start_line();
            if (cursor_col >= TERM_COLUMNS) cursor_col = 0;
            shadow_cells[newest_slot*TERM_COLUMNS + cursor_col] = {attr, w.character};
            cursor_col++;
            if (cursor_col >= TERM_COLUMNS) start_line();
          end
        end
        OP_ERASE: erase_cell();
        OP_SCROLL_UP: begin
          span = deepest_back();
          lines_back = (lines_back + w.amount > span) ? span : lines_back + w.amount;
        end
        OP_SCROLL_DOWN: lines_back = (w.amount >= lines_back) ? 0 : lines_back - w.amount;
        OP_SCROLL_BOTTOM: lines_back = 0;
        OP_CLEAR: begin
          line_total  = 0;
          newest_slot = 0;
          cursor_col  = 0;
          lines_back  = 0;
          start_line();
        end
        OP_READ_CELL: begin
          if (w.view_row < TERM_ROWS && w.view_column < TERM_COLUMNS) begin
            idx = deepest_back() - lines_back + w.view_row;
            if (idx >= line_total) begin
              r.cell_value = blank();
            end else begin
              slot = (newest_slot + TERM_HISTORY - (line_total - 1 - idx)) % TERM_HISTORY;
              r.cell_value = shadow_cells[slot*TERM_COLUMNS + w.view_column];
            end
          end
        end
        default: ;
      endcase
      if (line_total > 0) begin
        crow = ((line_total < TERM_ROWS) ? line_total : TERM_ROWS) - 1 + lines_back;
        if (crow < TERM_ROWS) begin
          r.cursor_visible  = 1'b1;
          r.cursor_position = 11'(crow*TERM_COLUMNS + cursor_col);
        end
      end
      r.scrolled_back = 8'(lines_back);
      pending_status.push_back(r);
    endfunction

    function void check_status(result_t got);
      result_t want;
      if (pending_status.size() == 0) begin
        failures++;
        if (failures <= 10) $display("unexpected result word %h", got);
        return;
      end
      want = pending_status.pop_front();
      if (got.cell_value !== want.cell_value || got.cursor_position !== want.cursor_position ||
          got.cursor_visible !== want.cursor_visible ||
          got.scrolled_back !== want.scrolled_back) begin
        failures++;
        if (failures <= 10)
          $display("mismatch: exp cell %h pos %0d vis %0b back %0d,",
                   want.cell_value, want.cursor_position, want.cursor_visible,
                   want.scrolled_back,
                   " got cell %h pos %0d vis %0b back %0d",
                   got.cell_value, got.cursor_position, got.cursor_visible,
                   got.scrolled_back);
      end
    endfunction
  endclass

endpackage

[dv/text_terminal_scrollback_unit_tb.sv]
// text_terminal_scrollback_unit_tb: self-checking bench for the scrollback unit
// drives directed and random words under varying idling; uses tts_pkg, tts_scoreboard_pkg
module text_terminal_scrollback_unit_tb;
  import tts_pkg::*;
  import tts_scoreboard_pkg::*;

  // code 7 has no name in the package, the block treats it as a no-op
  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int HOLD_OFF_CYCLES = 1000;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  item_t      in_data_i   = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  result_t    out_data_o;
  logic       cfg_we_i    = 1'b0;
  logic [7:0] cfg_wdata_i = '0;

  terminal_scoreboard tally;

  // idling percentages for each side, and the long receiver hold-off counter
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_left     = 0;

  text_terminal_scrollback_unit #(
    .HISTORY_LINES(TERM_HISTORY),
    .COLUMNS      (TERM_COLUMNS),
    .ROWS         (TERM_ROWS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // receiver: random stalls, or a counted hold-off that lets the block back up
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // both handshakes are observed at the rising edge, after the falling-edge drive
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) tally.apply_word(in_data_i);
      if (out_valid_o && out_ready_i) tally.check_status(out_data_o);
    end
  end

  // offer one word, with random gaps in front, and hold it until taken
  task automatic send_word(input item_t w);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_op(input logic [2:0] op, input logic [7:0] ch,
                         input logic [7:0] amt, input logic [4:0] row,
                         input logic [6:0] col);
    item_t w;
    w.operation   = op;
    w.character   = ch;
    w.amount      = amt;
    w.view_row    = row;
    w.view_column = col;
    send_word(w);
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_results_done();
    while (tally.pending() != 0) @(posedge clk_i);
  endtask

  // attribute writes only happen with the block idle and nothing outstanding
  task automatic write_attribute(input logic [7:0] value);
    stop_sending();
    wait_results_done();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    tally.set_attr(value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // weighted mix: many newlines so the history ring wraps, mostly in-window reads
  function automatic item_t random_word(input bit allow_clear);
    item_t       w;
    int unsigned pick;
    w.operation   = OP_PUT_CHAR;
    w.character   = 8'($urandom_range(0, 255));
    w.amount      = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                : 8'($urandom_range(0, 12));
    w.view_row    = ($urandom_range(0, 5) == 0) ? 5'($urandom_range(0, 31))
                                                : 5'($urandom_range(0, TERM_ROWS - 1));
    w.view_column = ($urandom_range(0, 5) == 0) ? 7'($urandom_range(0, 127))
                                                : 7'($urandom_range(0, TERM_COLUMNS - 1));
    pick = $urandom_range(0, 999);
    if (pick < 400) w.character = CH_NEWLINE;
    else if (pick < 600) w.character = 8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
    else if (pick < 630) w.character = CH_BACKSPACE;
    else if (pick < 645) w.character = CH_RETURN;
    else if (pick < 675) ;  // any byte, mostly ignored control or high codes
    else if (pick < 700) w.operation = OP_ERASE;
    else if (pick < 770) w.operation = OP_SCROLL_UP;
    else if (pick < 810) w.operation = OP_SCROLL_DOWN;
    else if (pick < 825) w.operation = OP_SCROLL_BOTTOM;
    else if (pick < 830) w.operation = allow_clear ? OP_CLEAR : OP_READ_CELL;
    else if (pick < 995) w.operation = OP_READ_CELL;
    else w.operation = OP_UNUSED;
    return w;
  endfunction

  // random words, now and then a run of printable text that can wrap a line
  task automatic run_random(input int words, input bit allow_clear);
    item_t w;
    int    sent;
    int    run_len;
    sent = 0;
    while (sent < words) begin
      if ($urandom_range(0, 149) == 0) begin
        run_len = $urandom_range(75, 90);
        repeat (run_len) begin
          w = random_word(1'b0);
          w.operation = OP_PUT_CHAR;
          w.character = 8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
          send_word(w);
        end
        sent += run_len;
      end else begin
        send_word(random_word(allow_clear));
        sent++;
      end
    end
  endtask

  initial begin
    tally = new();
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // phase one idling: sender rarely idles, receiver mostly stalls
    send_idle_pct = 9;
    recv_idle_pct = 74;

    // directed words with the reset attribute
    send_op(OP_READ_CELL, 8'h00, 8'h00, 5'd0, 7'd0);        // read with no line yet
    send_op(OP_ERASE, 8'h00, 8'h00, 5'd0, 7'd0);            // erase with no line
    send_op(OP_PUT_CHAR, CH_BACKSPACE, 8'h00, 5'd0, 7'd0);  // backspace with no line
    send_op(OP_PUT_CHAR, "A", 8'h00, 5'd0, 7'd0);           // first character starts a line
    send_op(OP_PUT_CHAR, "B", 8'h00, 5'd0, 7'd0);
    send_op(OP_PUT_CHAR, CH_RETURN, 8'h00, 5'd0, 7'd0);
    send_op(OP_PUT_CHAR, "C", 8'h00, 5'd0, 7'd0);           // overwrite after return
    send_op(OP_PUT_CHAR, CH_BACKSPACE, 8'h00, 5'd0, 7'd0);
    send_op(OP_ERASE, 8'h00, 8'h00, 5'd0, 7'd0);            // erase at column zero
    send_op(OP_PUT_CHAR, CH_PRINT_HI, 8'h00, 5'd0, 7'd0);   // top printable code
    send_op(OP_PUT_CHAR, 8'h80, 8'h00, 5'd0, 7'd0);         // high bytes are ignored
    send_op(OP_PUT_CHAR, 8'hFF, 8'h00, 5'd0, 7'd0);
    send_op(OP_PUT_CHAR, 8'h1F, 8'h00, 5'd0, 7'd0);         // control bytes are ignored
    send_op(OP_PUT_CHAR, 8'h00, 8'h00, 5'd0, 7'd0);
    send_op(OP_PUT_CHAR, CH_NEWLINE, 8'h00, 5'd0, 7'd0);
    send_op(OP_SCROLL_UP, 8'h00, 8'hFF, 5'd0, 7'd0);        // clamped with short history
    send_op(OP_SCROLL_DOWN, 8'h00, 8'hFF, 5'd0, 7'd0);
    send_op(OP_SCROLL_BOTTOM, 8'h00, 8'h00, 5'd0, 7'd0);
    send_op(OP_READ_CELL, 8'h00, 8'h00, 5'd0, 7'd0);
    send_op(OP_READ_CELL, 8'h00, 8'h00, 5'd24, 7'd79);      // past written lines
    send_op(OP_READ_CELL, 8'h00, 8'h00, 5'd25, 7'd0);       // row outside the window
    send_op(OP_READ_CELL, 8'h00, 8'h00, 5'd31, 7'd127);     // both outside
    send_op(OP_CLEAR, 8'h00, 8'h00, 5'd0, 7'd0);
    send_op(OP_UNUSED, 8'hFF, 8'hFF, 5'd31, 7'd127);
    send_op(OP_PUT_CHAR, CH_SPACE, 8'h00, 5'd0, 7'd0);      // lowest printable code

    write_attribute(8'hFF);

    // receiver holds off while words keep coming, so the input backs up
    @(posedge clk_i);
    hold_left = HOLD_OFF_CYCLES;
    run_random(30, 1'b1);
    run_random(230, 1'b1);
    // sender pauses until every outstanding result has come back
    stop_sending();
    wait_results_done();
    run_random(260, 1'b1);

    // phase two: the other way round, no clears so the ring wraps
    write_attribute(8'h00);
    send_idle_pct = 74;
    recv_idle_pct = 9;
    run_random(530, 1'b0);

    // phase three: no idling at all
    write_attribute(8'($urandom_range(0, 255)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(530, 1'b0);

    stop_sending();
    wait_results_done();
    repeat (200) @(posedge clk_i);
    if (tally.failures == 0 && tally.pending() == 0) begin
      $display("text_terminal_scrollback_unit_tb: clean");
    end else begin
      $display("text_terminal_scrollback_unit_tb: errors");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #4000000;
    $display("text_terminal_scrollback_unit_tb: errors");
    $finish;
  end

endmodule
